// File: hdl/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
// No dependencies; imported by tcce_front, tcce_back and the top level.
`default_nettype none

package tcce_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STEP_DEF = 4;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;

    localparam int CFG_DW = 4;
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_PAINT = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        K_PUT,
        K_NEWLINE,
        K_BACKSPACE,
        K_TAB,
        K_CLEAR,
        K_PAINT,
        K_READ
    } t_kind;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [10:0] cursor_after;
        logic        scrolled;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [10:0] addr;
        logic        addr_ok;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_if;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_FILL,
        S_SCROLL_COPY,
        S_SCROLL_ZERO
    } t_state;

endpackage

`default_nettype wire

// File: hdl/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/tcce_front.sv
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on tcce_pkg.
`default_nettype none

module tcce_front #(
    parameter int CELLS = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire tcce_pkg::t_in  i_in_data,
    input  wire logic           i_ready,
    output tcce_pkg::t_cmd_if   o_cmd,
    input  wire logic           i_pop
);
    import tcce_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       cls;
    logic       push;
    logic       full;

    always_comb begin
        cls.ch      = i_in_data.char_code;
        cls.addr    = i_in_data.cell_address;
        cls.addr_ok = int'(i_in_data.cell_address) < CELLS;
        unique case (t_action'(i_in_data.action))
            ACT_PUT: begin
                priority if (i_in_data.char_code == CH_NEWLINE) begin
                    cls.kind = K_NEWLINE;
                end else if (i_in_data.char_code == CH_BACKSPACE) begin
                    cls.kind = K_BACKSPACE;
                end else if (i_in_data.char_code == CH_TAB) begin
                    cls.kind = K_TAB;
                end else begin
                    cls.kind = K_PUT;
                end
            end
            ACT_CLEAR: cls.kind = K_CLEAR;
            ACT_PAINT: cls.kind = K_PAINT;
            ACT_READ:  cls.kind = K_READ;
            default:   cls.kind = K_READ;
        endcase
    end

    assign full       = r_count == 2'd2;
    assign o_in_stall = full | ~i_ready;
    assign push       = i_in_valid & ~o_in_stall;

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    assign o_cmd.valid = r_count != 2'd0;
    assign o_cmd.cmd   = r_q[r_rp];

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("pop from empty request queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("request queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: hdl/tcce_back.sv
// Back end: executes queued requests on the cell buffer, owns cursor, colors
// and the result register. Depends on tcce_pkg and tcce_ram.
`default_nettype none

module tcce_back #(
    parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcce_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcce_pkg::TAB_STEP_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [tcce_pkg::CFG_DW-1:0] i_cfg_data,
    input  wire tcce_pkg::t_cmd_if           i_cmd,
    output logic                             o_pop,
    output logic                             o_ready,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output tcce_pkg::t_out                   o_out_data
);
    import tcce_pkg::*;

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int AW      = $clog2(CELLS);
    localparam int CLW     = $clog2(COLUMNS);
    localparam int TAB_MOD = TAB_STEP % COLUMNS;

    localparam logic [AW:0]    CELLS_X   = (AW+1)'(CELLS);
    localparam logic [AW-1:0]  LAST_ROW  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0]  COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0]  CELL_LAST = AW'(CELLS - 1);
    localparam logic [CLW-1:0] COL_LAST  = CLW'(COLUMNS - 1);

    t_state         r_state, n_state;
    logic [AW-1:0]  r_cur, n_cur;
    logic [CLW-1:0] r_col, n_col;
    logic [AW-1:0]  r_cnt, n_cnt;
    logic [15:0]    r_fill, n_fill;
    logic           r_rd_ok, n_rd_ok;
    logic           r_pend, n_pend;
    logic [AW-1:0]  r_pend_addr, n_pend_addr;
    logic [3:0]     r_fg, r_bg;
    logic           r_out_valid, n_out_valid;
    t_out           r_out_data, n_out_data;

    logic           out_free;
    logic           emit;
    logic [AW:0]    sum_cur;
    logic [CLW:0]   col_sum;
    logic [CLW-1:0] step_col;
    logic           eng_we;
    logic [AW-1:0]  eng_waddr;
    logic [15:0]    eng_wdata;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_q;
    logic [15:0]    color;

    assign color    = {r_bg, r_fg, 8'd0};
    assign out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FG:  r_fg <= i_cfg_data;
                REG_BG:  r_bg <= i_cfg_data;
                default: r_fg <= r_fg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cur       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill      <= n_fill;
        r_rd_ok     <= n_rd_ok;
        r_pend_addr <= n_pend_addr;
        r_out_data  <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_rd_ok     = r_rd_ok;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_out_data  = r_out_data;
        emit        = 1'b0;
        o_pop       = 1'b0;
        eng_we      = 1'b0;
        eng_waddr   = r_cnt;
        eng_wdata   = 16'd0;
        ram_raddr   = r_cnt;
        sum_cur     = {1'b0, r_cur};
        col_sum     = {1'b0, r_col};
        step_col    = r_col;

        unique case (r_state)
            S_INIT: begin
                eng_we = 1'b1;
                n_cnt  = r_cnt + AW'(1);
                if (r_cnt == CELL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid && out_free) begin
                    o_pop = 1'b1;
                    n_out_data.read_data = 16'd0;
                    n_out_data.scrolled  = 1'b0;
                    unique case (i_cmd.cmd.kind)
                        K_PUT, K_NEWLINE, K_BACKSPACE, K_TAB: begin
                            unique case (i_cmd.cmd.kind)
                                K_PUT: begin
                                    eng_we    = 1'b1;
                                    eng_waddr = r_cur;
                                    eng_wdata = color | {8'd0, i_cmd.cmd.ch};
                                    sum_cur   = {1'b0, r_cur} + (AW+1)'(1);
                                    step_col  = (r_col == COL_LAST) ? '0
                                                                    : r_col + CLW'(1);
                                end
                                K_NEWLINE: begin
                                    sum_cur  = {1'b0, r_cur} + (AW+1)'(COLUMNS)
                                               - (AW+1)'(r_col);
                                    step_col = '0;
                                end
                                K_BACKSPACE: begin
                                    if (r_cur != '0) begin
                                        eng_we    = 1'b1;
                                        eng_waddr = r_cur - AW'(1);
                                        eng_wdata = color;
                                        sum_cur   = {1'b0, r_cur} - (AW+1)'(1);
                                        step_col  = (r_col == '0) ? COL_LAST
                                                                  : r_col - CLW'(1);
                                    end
                                end
                                default: begin
                                    // tab: column wraps at most once per step
                                    sum_cur  = {1'b0, r_cur} + (AW+1)'(TAB_STEP);
                                    col_sum  = {1'b0, r_col} + (CLW+1)'(TAB_MOD);
                                    step_col = (col_sum >= (CLW+1)'(COLUMNS))
                                             ? CLW'(col_sum - (CLW+1)'(COLUMNS))
                                             : CLW'(col_sum);
                                end
                            endcase
                            if (sum_cur >= CELLS_X) begin
                                n_cur   = LAST_ROW;
                                n_col   = '0;
                                n_cnt   = '0;
                                n_state = S_SCROLL_COPY;
                            end else begin
                                n_cur = AW'(sum_cur);
                                n_col = step_col;
                                emit  = 1'b1;
                                n_out_data.cursor_after = 11'(sum_cur);
                            end
                        end
                        K_CLEAR, K_PAINT: begin
                            n_fill  = (i_cmd.cmd.kind == K_PAINT) ? color : 16'd0;
                            n_cur   = '0;
                            n_col   = '0;
                            n_cnt   = '0;
                            n_state = S_FILL;
                        end
                        default: begin
                            ram_raddr = AW'(i_cmd.cmd.addr);
                            n_rd_ok   = i_cmd.cmd.addr_ok;
                            n_state   = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                emit = 1'b1;
                n_out_data.read_data    = r_rd_ok ? ram_q : 16'd0;
                n_out_data.cursor_after = 11'(r_cur);
                n_out_data.scrolled     = 1'b0;
                n_state = S_IDLE;
            end
            S_FILL: begin
                eng_we    = 1'b1;
                eng_wdata = r_fill;
                n_cnt     = r_cnt + AW'(1);
                if (r_cnt == CELL_LAST) begin
                    emit = 1'b1;
                    n_out_data.read_data    = 16'd0;
                    n_out_data.cursor_after = 11'(r_cur);
                    n_out_data.scrolled     = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_SCROLL_COPY: begin
                // read one row ahead, write back on the next cycle
                ram_raddr   = r_cnt + AW'(COLUMNS);
                n_pend      = 1'b1;
                n_pend_addr = r_cnt;
                n_cnt       = r_cnt + AW'(1);
                if (r_cnt == COPY_LAST) begin
                    n_cnt   = LAST_ROW;
                    n_state = S_SCROLL_ZERO;
                end
            end
            S_SCROLL_ZERO: begin
                if (!r_pend) begin
                    eng_we = 1'b1;
                    n_cnt  = r_cnt + AW'(1);
                    if (r_cnt == CELL_LAST) begin
                        emit = 1'b1;
                        n_out_data.read_data    = 16'd0;
                        n_out_data.cursor_after = 11'(r_cur);
                        n_out_data.scrolled     = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = emit | (r_out_valid & i_out_stall);
    end

    // pending scroll copy has the write port first
    assign ram_we    = r_pend | eng_we;
    assign ram_waddr = r_pend ? r_pend_addr : eng_waddr;
    assign ram_wdata = r_pend ? ram_q : eng_wdata;

    tcce_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign o_ready     = r_state != S_INIT;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cur) < CELLS) && (int'(r_col) < COLUMNS))
        else $error("cursor out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit)
        else $error("result register overwritten while stalled");
    a_pend_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCROLL_COPY || r_state == S_SCROLL_ZERO))
        else $error("copy write pending outside scroll");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && i_cmd.valid && !r_pend))
        else $error("request taken while engine busy");

endmodule

`default_nettype wire

// File: hdl/text_console_cursor_engine.sv
// Result timing: put, newline, backspace and tab without a scroll give their result
// in the cycle after the request is taken; read goes through S_READ and the
// registered buffer read. Throughput: one put per cycle while no scroll occurs and
// the output is not stalled; a scroll, clear and paint hold the engine for a full
// pass over the buffer (one buffer port). Reset: synchronous; a clearing pass
// zeroes the buffer while o_in_stall is high. Configuration writes are taken at any time.
// Top level; depends on tcce_pkg, tcce_front, tcce_back and tcce_ram.
`default_nettype none

module text_console_cursor_engine #(
    parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcce_pkg::ROWS_DEF,
    parameter int TAB_STEP = tcce_pkg::TAB_STEP_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire tcce_pkg::t_in               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output tcce_pkg::t_out                   o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [tcce_pkg::CFG_DW-1:0] i_cfg_data
);
    import tcce_pkg::*;

    t_cmd_if cmd;
    logic    pop;
    logic    ready;

    tcce_front #(
        .CELLS (COLUMNS * ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_ready    (ready),
        .o_cmd      (cmd),
        .i_pop      (pop)
    );

    tcce_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
